>>> sv/cscan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscan_pkg
// Shared types and constants of the C-SCAN disk scheduler.
// ----------------------------------------------------------------------------
package cscan_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int CYL_W        = 16;
  localparam int CFG_W        = 17;
  localparam int SEEK_W       = 18;
  localparam int STEP_W       = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  localparam logic [CFG_W-1:0]  CYLINDERS_RESET = CFG_W'(200);
  localparam logic [SEEK_W-1:0] SEEK_MAX        = {SEEK_W{1'b1}};

  // what every cell of the chain does in a cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT_DN,   // take the entry of the next cell (toward cell 0)
    CELL_SHIFT_UP,   // take the entry of the previous cell (away from cell 0)
    CELL_CLEAR
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS1,
    ST_WRAP,
    ST_PASS2,
    ST_SUMMARY
  } state_e;

  typedef struct packed {
    cell_op_e         op;
    logic [CYL_W-1:0] req;
  } chain_ctrl_t;

  typedef struct packed {
    logic             valid;
    logic [CYL_W-1:0] value;
  } cell_t;

endpackage

>>> sv/cscan_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscan_cell
// One entry of the sorted request chain: holds a cylinder and an occupied
// flag, inserts in order against its lower neighbor and rotates either way.
// ----------------------------------------------------------------------------
module cscan_cell
  import cscan_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  chain_ctrl_t ctrl_i,
  input  cell_t       lo_i,       // previous cell, circular
  input  cell_t       hi_i,       // next cell, circular
  input  logic        lo_gt_i,    // previous cell holds a value above the request
  input  logic        lo_open_i,  // previous cell is occupied (or this is cell 0)
  output cell_t       cell_o,
  output logic        gt_o
);

  logic             valid_q, valid_d;
  logic [CYL_W-1:0] value_q, value_d;
  logic             take;

  assign gt_o = valid_q && (value_q > ctrl_i.req);
  // push own entry up, or claim the first free slot
  assign take = gt_o || (!valid_q && lo_open_i);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (take) begin
          valid_d = 1'b1;
          value_d = lo_gt_i ? lo_i.value : ctrl_i.req;
        end
      end
      CELL_SHIFT_DN: begin
        valid_d = hi_i.valid;
        value_d = hi_i.value;
      end
      CELL_SHIFT_UP: begin
        valid_d = lo_i.valid;
        value_d = lo_i.value;
      end
      CELL_CLEAR: valid_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o = '{valid: valid_q, value: value_q};

endmodule

>>> sv/cscan_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscan_chain
// Row of request cells, kept in ascending order from cell 0 up, closed into
// a ring for the service sweeps.
// ----------------------------------------------------------------------------
module cscan_chain
  import cscan_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  chain_ctrl_t ctrl_i,
  output cell_t       first_o,
  output cell_t       last_o
);

  cell_t cells [MAX_REQUESTS];
  logic  gts   [MAX_REQUESTS];

  for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
    localparam int LO = (i + MAX_REQUESTS - 1) % MAX_REQUESTS;
    localparam int HI = (i + 1) % MAX_REQUESTS;
    logic lo_gt;
    logic lo_open;
    if (i == 0) begin : g_first
      assign lo_gt   = 1'b0;
      assign lo_open = 1'b1;
    end else begin : g_rest
      assign lo_gt   = gts[LO];
      assign lo_open = cells[LO].valid;
    end
    cscan_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl_i),
      .lo_i      (cells[LO]),
      .hi_i      (cells[HI]),
      .lo_gt_i   (lo_gt),
      .lo_open_i (lo_open),
      .cell_o    (cells[i]),
      .gt_o      (gts[i])
    );
  end

  assign first_o = cells[0];
  assign last_o  = cells[MAX_REQUESTS-1];

endmodule

>>> sv/cscan_disk_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscan_disk_scheduler
// C-SCAN disk request scheduler built on a sorted chain of cells.
//
// Slave stream: tuser = 0 loads the request cylinder into the sorted chain
// (dropped when the chain is full, no result). tuser = 1 runs the schedule
// from the given head cylinder and direction. A run rotates the chain ring
// twice, one full turn per pass, with a wrap step between the passes and
// a summary step at the end. The first pass serves the requests ahead of
// the head, the second the ones behind it; each served request gives one
// result, the run ends with a summary result (tlast) carrying the total
// seek distance, and the chain is emptied.
// The slave side takes one request per cycle while no run is in progress.
// Results sit in an output register; when the receiver stalls, the sweep
// holds on the next request to be served. Reset empties the chain and sets
// disk_cylinders to 200. Write cfg_wdata_i only while idle.
// ----------------------------------------------------------------------------
module cscan_disk_scheduler
  import cscan_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,     // disk_cylinders
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [39:0]      s_axis_tdata,    // request_cylinder, head_position, direction
  input  logic             s_axis_tuser,    // kind
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,    // serviced_cylinder, cylinder_valid, seek_total
  output logic             m_axis_tlast     // last
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_REQUESTS - 1);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CFG_W-1:0]  cyls_q;
  logic [SEEK_W-1:0] seek_q, seek_d;
  logic [CFG_W-1:0]  pos_q, pos_d;
  logic [CFG_W-1:0]  lastc_q, lastc_d;
  logic [CYL_W-1:0]  start_q;
  logic              dir_q;
  logic              run_start;

  logic              out_valid_q, out_valid_d;
  logic [CYL_W-1:0]  out_cyl_q, out_cyl_d;
  logic              out_cv_q, out_cv_d;
  logic [SEEK_W-1:0] out_seek_q, out_seek_d;
  logic              out_last_q, out_last_d;
  logic              out_load;
  logic              out_free;

  chain_ctrl_t       ctrl;
  cell_t             chain_first, chain_last, cand;

  logic              in_acc;
  logic              upper, want;
  logic [CFG_W-1:0]  cand_cyl, serve_dist, wrap_d1;
  logic [SEEK_W:0]   serve_sum;
  logic [SEEK_W+1:0] wrap_sum;
  logic [SEEK_W-1:0] serve_seek, wrap_seek;

  cscan_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .first_o (chain_first),
    .last_o  (chain_last)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // upward sweep drains cell 0, downward sweep drains the top cell
  assign cand     = dir_q ? chain_first : chain_last;
  assign cand_cyl = {1'b0, cand.value};
  assign upper    = (cand.value >= start_q);
  assign want     = cand.valid && (upper ^ (state_q == ST_PASS2) ^ !dir_q);

  assign serve_dist = (cand_cyl >= pos_q) ? cand_cyl - pos_q : pos_q - cand_cyl;
  assign serve_sum  = {1'b0, seek_q} + {2'b00, serve_dist};
  assign serve_seek = serve_sum[SEEK_W] ? SEEK_MAX : serve_sum[SEEK_W-1:0];

  // sweep to the end, then wrap across the disk, in one step
  assign wrap_d1    = dir_q ? ((lastc_q >= pos_q) ? lastc_q - pos_q : pos_q - lastc_q)
                            : pos_q;
  assign wrap_sum   = {2'b00, seek_q} + {3'b000, wrap_d1} + {3'b000, lastc_q};
  assign wrap_seek  = (wrap_sum > {2'b00, SEEK_MAX}) ? SEEK_MAX : wrap_sum[SEEK_W-1:0];

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    seek_d     = seek_q;
    pos_d      = pos_q;
    lastc_d    = lastc_q;
    run_start  = 1'b0;
    ctrl.op    = CELL_HOLD;
    ctrl.req   = s_axis_tdata[15:0];
    out_load   = 1'b0;
    out_cyl_d  = out_cyl_q;
    out_cv_d   = out_cv_q;
    out_seek_d = out_seek_q;
    out_last_d = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!s_axis_tuser) begin
            // drop the request when the chain is full
            if (!chain_last.valid) ctrl.op = CELL_INSERT;
          end else begin
            run_start = 1'b1;
            seek_d    = '0;
            pos_d     = {1'b0, s_axis_tdata[31:16]};
            lastc_d   = (cyls_q == '0) ? '0 : cyls_q - CFG_W'(1);
            step_d    = '0;
            state_d   = ST_PASS1;
          end
        end
      end
      ST_PASS1, ST_PASS2: begin
        if (!want || out_free) begin
          ctrl.op = dir_q ? CELL_SHIFT_DN : CELL_SHIFT_UP;
          if (want) begin
            out_load   = 1'b1;
            out_cyl_d  = cand.value;
            out_cv_d   = 1'b1;
            out_seek_d = serve_seek;
            out_last_d = 1'b0;
            seek_d     = serve_seek;
            pos_d      = cand_cyl;
          end
          step_d = step_q + STEP_W'(1);
          if (step_q == LAST_STEP) begin
            step_d  = '0;
            state_d = (state_q == ST_PASS1) ? ST_WRAP : ST_SUMMARY;
          end
        end
      end
      ST_WRAP: begin
        seek_d  = wrap_seek;
        pos_d   = dir_q ? '0 : lastc_q;
        state_d = ST_PASS2;
      end
      ST_SUMMARY: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_cyl_d  = '0;
          out_cv_d   = 1'b0;
          out_seek_d = seek_q;
          out_last_d = 1'b1;
          ctrl.op    = CELL_CLEAR;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cyls_q      <= CYLINDERS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) cyls_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    seek_q     <= seek_d;
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    lastc_q    <= lastc_d;
    out_cyl_q  <= out_cyl_d;
    out_cv_q   <= out_cv_d;
    out_seek_q <= out_seek_d;
    out_last_q <= out_last_d;
    if (run_start) begin
      start_q <= s_axis_tdata[31:16];
      dir_q   <= s_axis_tdata[32];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_seek_q, out_cv_q, out_cyl_q};
  assign m_axis_tlast  = out_last_q;

  // seek distance only grows while a run is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && $past(state_q) != ST_IDLE) |-> seek_q >= $past(seek_q))
    else $error("seek total decreased during a run");

  // a new result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result register overwritten");

  // the chain is empty once the summary has been issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUMMARY && out_free) |=> !chain_first.valid && !chain_last.valid)
    else $error("chain not emptied after run");

  // a request into a full chain leaves the top entry in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tuser && chain_last.valid)
      |=> chain_last.valid && $stable(chain_last.value))
    else $error("full chain changed by a dropped request");

endmodule
